// ----- rtl/qes_pkg.sv -----
// Shared types and constants for the quadrature encoder speed core.
// Used by qes_phase, qes_channel and quadrature_encoder_speed_core; no dependencies.
package qes_pkg;

  localparam int OUT_CH     = 4;
  localparam int PIN_BITS   = 8;
  localparam int DELTA_BITS = 16;
  localparam int GAIN_BITS  = 16;
  localparam int SPEED_BITS = 32;
  localparam int OUT_BITS   = 32;
  localparam int PHASE_BITS = 8;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  localparam int DELTA_MAX = 32767;
  localparam int DELTA_MIN = -32768;

  localparam logic [CFG_INDEX_BITS-1:0] REG_PERIOD   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SNAPSHOT = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MEASURE  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCALE    = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN     = 3'd4;

  localparam logic [PHASE_BITS-1:0] PERIOD_RESET   = 8'd20;
  localparam logic [PHASE_BITS-1:0] SNAPSHOT_RESET = 8'd1;
  localparam logic [PHASE_BITS-1:0] MEASURE_RESET  = 8'd11;
  localparam logic [PHASE_BITS-1:0] SCALE_RESET    = 8'd15;
  localparam logic [GAIN_BITS-1:0]  GAIN_RESET     = 16'd2806;

  typedef enum logic {
    REQ_PIN  = 1'b0,
    REQ_TICK = 1'b1
  } req_type_t;

  typedef struct packed {
    logic snap;
    logic meas;
    logic scal;
  } phase_hit_t;

endpackage

// ----- rtl/quadrature_encoder_speed_core.sv -----
// Four-channel x4 quadrature decoder with periodic speed measurement.
// An accepted request's result is registered and shows on the outputs in the next cycle;
// one request per cycle is taken unless out_valid is high with out_ready low. The count
// update and the delta-times-gain multiply feed the output register combinationally.
// Synchronous reset clears the channel counts and speeds, the phase counter and the output
// valid flag, and loads the register defaults. Depends on qes_pkg, qes_phase, qes_channel.
module quadrature_encoder_speed_core #(
  parameter int CHANNELS   = 4,
  parameter int COUNT_BITS = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [qes_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [qes_pkg::CFG_DATA_BITS-1:0]      cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   req_type,
  input  logic [qes_pkg::PIN_BITS-1:0]           enc_pins,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [qes_pkg::OUT_BITS-1:0]    count_ch0,
  output logic signed [qes_pkg::OUT_BITS-1:0]    count_ch1,
  output logic signed [qes_pkg::OUT_BITS-1:0]    count_ch2,
  output logic signed [qes_pkg::OUT_BITS-1:0]    count_ch3,
  output logic signed [qes_pkg::OUT_BITS-1:0]    speed_ch0,
  output logic signed [qes_pkg::OUT_BITS-1:0]    speed_ch1,
  output logic signed [qes_pkg::OUT_BITS-1:0]    speed_ch2,
  output logic signed [qes_pkg::OUT_BITS-1:0]    speed_ch3,
  output logic                                   speed_updated
);

  logic                                   accept;
  logic                                   pin_step;
  logic                                   tick_step;
  qes_pkg::phase_hit_t                    hits;
  logic [qes_pkg::GAIN_BITS-1:0]          speed_gain;
  logic signed [COUNT_BITS-1:0]           count_next [CHANNELS];
  logic signed [qes_pkg::SPEED_BITS-1:0]  speed_next [CHANNELS];
  logic signed [qes_pkg::OUT_BITS-1:0]    count_res  [qes_pkg::OUT_CH];
  logic signed [qes_pkg::OUT_BITS-1:0]    speed_res  [qes_pkg::OUT_CH];
  logic signed [qes_pkg::OUT_BITS-1:0]    count_q    [qes_pkg::OUT_CH];
  logic signed [qes_pkg::OUT_BITS-1:0]    speed_q    [qes_pkg::OUT_CH];

  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign pin_step  = accept && (req_type == qes_pkg::REQ_PIN);
  assign tick_step = accept && (req_type == qes_pkg::REQ_TICK);

  qes_phase u_phase (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .tick_step  (tick_step),
    .hits       (hits),
    .speed_gain (speed_gain)
  );

  for (genvar k = 0; k < CHANNELS; k++) begin : g_ch
    logic pin_a;
    logic pin_b;
    if (2 * k + 1 < qes_pkg::PIN_BITS) begin : g_pins
      assign pin_a = enc_pins[2*k];
      assign pin_b = enc_pins[2*k+1];
    end else begin : g_no_pins
      assign pin_a = 1'b0;
      assign pin_b = 1'b0;
    end

    qes_channel #(
      .COUNT_BITS (COUNT_BITS)
    ) u_ch (
      .clk        (clk),
      .rst        (rst),
      .pin_step   (pin_step),
      .tick_step  (tick_step),
      .hits       (hits),
      .pin_a      (pin_a),
      .pin_b      (pin_b),
      .speed_gain (speed_gain),
      .count_next (count_next[k]),
      .speed_next (speed_next[k])
    );
  end

  for (genvar k = 0; k < qes_pkg::OUT_CH; k++) begin : g_out
    if (k < CHANNELS) begin : g_used
      assign count_res[k] = qes_pkg::OUT_BITS'(count_next[k]);
      assign speed_res[k] = speed_next[k];
    end else begin : g_absent
      assign count_res[k] = '0;
      assign speed_res[k] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      count_q       <= count_res;
      speed_q       <= speed_res;
      speed_updated <= tick_step && hits.scal;
    end
  end

  assign count_ch0 = count_q[0];
  assign count_ch1 = count_q[1];
  assign count_ch2 = count_q[2];
  assign count_ch3 = count_q[3];
  assign speed_ch0 = speed_q[0];
  assign speed_ch1 = speed_q[1];
  assign speed_ch2 = speed_q[2];
  assign speed_ch3 = speed_q[3];

  a_pin_no_update: assert property (@(posedge clk) disable iff (rst)
    pin_step |=> out_valid && !speed_updated)
    else $error("pin sample request flagged a speed update");

  a_pin_keeps_speed: assert property (@(posedge clk) disable iff (rst)
    pin_step && out_valid |=> $stable(speed_ch0) && $stable(speed_ch3))
    else $error("pin sample request changed a speed");

  a_tick_keeps_count: assert property (@(posedge clk) disable iff (rst)
    tick_step && out_valid |=> $stable(count_ch0) && $stable(count_ch3))
    else $error("tick request changed a position count");

endmodule

// ----- rtl/qes_phase.sv -----
// Configuration registers and millisecond phase counter.
// Depends on qes_pkg; produces the phase match flags for the next tick.
module qes_phase (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [qes_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [qes_pkg::CFG_DATA_BITS-1:0]      cfg_data,
  input  logic                                   tick_step,
  output qes_pkg::phase_hit_t                    hits,
  output logic [qes_pkg::GAIN_BITS-1:0]          speed_gain
);

  logic [qes_pkg::PHASE_BITS-1:0] period_ticks;
  logic [qes_pkg::PHASE_BITS-1:0] snapshot_phase;
  logic [qes_pkg::PHASE_BITS-1:0] measure_phase;
  logic [qes_pkg::PHASE_BITS-1:0] scale_phase;
  logic [qes_pkg::PHASE_BITS-1:0] phase_count;
  logic [qes_pkg::PHASE_BITS-1:0] phase_count_next;
  logic [qes_pkg::PHASE_BITS:0]   phase_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      period_ticks   <= qes_pkg::PERIOD_RESET;
      snapshot_phase <= qes_pkg::SNAPSHOT_RESET;
      measure_phase  <= qes_pkg::MEASURE_RESET;
      scale_phase    <= qes_pkg::SCALE_RESET;
      speed_gain     <= qes_pkg::GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        qes_pkg::REG_PERIOD:   period_ticks   <= cfg_data[qes_pkg::PHASE_BITS-1:0];
        qes_pkg::REG_SNAPSHOT: snapshot_phase <= cfg_data[qes_pkg::PHASE_BITS-1:0];
        qes_pkg::REG_MEASURE:  measure_phase  <= cfg_data[qes_pkg::PHASE_BITS-1:0];
        qes_pkg::REG_SCALE:    scale_phase    <= cfg_data[qes_pkg::PHASE_BITS-1:0];
        qes_pkg::REG_GAIN:     speed_gain     <= cfg_data[qes_pkg::GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // A period of zero lets the counter wrap through all 256 phases.
  always_comb begin
    phase_inc = {1'b0, phase_count} + 1'b1;
    if (period_ticks != '0 && phase_inc >= {1'b0, period_ticks}) begin
      phase_count_next = '0;
    end else begin
      phase_count_next = phase_inc[qes_pkg::PHASE_BITS-1:0];
    end
    hits.snap = (phase_count_next == snapshot_phase);
    hits.meas = (phase_count_next == measure_phase);
    hits.scal = (phase_count_next == scale_phase);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_count <= '0;
    end else if (tick_step) begin
      phase_count <= phase_count_next;
    end
  end

endmodule

// ----- rtl/qes_channel.sv -----
// One encoder channel: x4 position counter, reference, saturated delta and speed.
// Depends on qes_pkg; the top level instantiates one per channel.
module qes_channel #(
  parameter int COUNT_BITS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  pin_step,
  input  logic                                  tick_step,
  input  qes_pkg::phase_hit_t                   hits,
  input  logic                                  pin_a,
  input  logic                                  pin_b,
  input  logic [qes_pkg::GAIN_BITS-1:0]         speed_gain,
  output logic signed [COUNT_BITS-1:0]          count_next,
  output logic signed [qes_pkg::SPEED_BITS-1:0] speed_next
);

  localparam logic signed [COUNT_BITS-1:0] DMAX = COUNT_BITS'(qes_pkg::DELTA_MAX);
  localparam logic signed [COUNT_BITS-1:0] DMIN = COUNT_BITS'(qes_pkg::DELTA_MIN);

  logic                                   prev_a;
  logic                                   prev_b;
  logic signed [COUNT_BITS-1:0]           position;
  logic signed [COUNT_BITS-1:0]           reference;
  logic signed [qes_pkg::DELTA_BITS-1:0]  delta;
  logic signed [qes_pkg::DELTA_BITS-1:0]  delta_next;
  logic signed [qes_pkg::SPEED_BITS-1:0]  speed;
  logic signed [COUNT_BITS-1:0]           diff;
  logic signed [qes_pkg::SPEED_BITS:0]    product;
  logic                                   dec;
  logic                                   inc;

  always_comb begin
    dec = pin_a ^ prev_b;
    inc = pin_b ^ prev_a;
    count_next = position;
    if (pin_step && inc && !dec) begin
      count_next = position + COUNT_BITS'(1);
    end else if (pin_step && dec && !inc) begin
      count_next = position - COUNT_BITS'(1);
    end
  end

  always_comb begin
    diff = position - reference;
    if (diff > DMAX) begin
      delta_next = qes_pkg::DELTA_BITS'(qes_pkg::DELTA_MAX);
    end else if (diff < DMIN) begin
      delta_next = qes_pkg::DELTA_BITS'(qes_pkg::DELTA_MIN);
    end else begin
      delta_next = diff[qes_pkg::DELTA_BITS-1:0];
    end
  end

  // The scale action uses the delta held before this tick.
  always_comb begin
    product = delta * $signed({1'b0, speed_gain});
    speed_next = speed;
    if (tick_step && hits.scal) begin
      speed_next = product[qes_pkg::SPEED_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_a    <= 1'b0;
      prev_b    <= 1'b0;
      position  <= '0;
      reference <= '0;
      delta     <= '0;
      speed     <= '0;
    end else begin
      position <= count_next;
      speed    <= speed_next;
      if (pin_step) begin
        prev_a <= pin_a;
        prev_b <= pin_b;
      end
      if (tick_step && hits.meas) begin
        delta <= delta_next;
      end
      if (tick_step && hits.snap) begin
        reference <= position;
      end
    end
  end

endmodule
